FILE: rtl/twa_pkg.sv
`timescale 1ns / 1ps

package twa_pkg;

  // Sample and average width.
  localparam int SAMPLE_W = 16;

  // Running total width: 16 samples of 16 bits cannot overflow 21 signed bits.
  localparam int SUM_W = 21;

  // Largest divisor the constant divider is built for.
  localparam int DIV_LIMIT = 16;

  localparam int DEF_SAMPLES_PER_WINDOW = 5;
  localparam int DEF_SKIPPED_WINDOWS    = 4;

  // One closed window handed from the accumulator to the output stage.
  typedef struct packed {
    logic signed [SUM_W-1:0] temp_total;
    logic signed [SUM_W-1:0] hum_total;
    logic signed [SUM_W-1:0] dust_total;
    logic                    dust_measured;
    logic                    next_measures;
  } twa_window_t;

  // Window handoff control, accumulator side to output side.
  typedef struct packed {
    logic valid;
  } twa_win_req_t;

  // Window handoff control, output side to accumulator side.
  typedef struct packed {
    logic take;
  } twa_win_rsp_t;

endpackage

FILE: rtl/twa_div.sv
`timescale 1ns / 1ps

// Signed divide by a constant, truncating toward zero.
// Magnitude times a rounded-up reciprocal; exact for every reachable total.
module twa_div #(
  parameter int DIVISOR = twa_pkg::DEF_SAMPLES_PER_WINDOW
) (
  input  logic signed [twa_pkg::SUM_W-1:0]    total,
  output logic signed [twa_pkg::SAMPLE_W-1:0] average
);
  import twa_pkg::*;

  // |total| <= 16 * 2^15 = 2^19, so 20 magnitude bits are enough.
  localparam int MAG_W   = SUM_W - 1;
  // Reciprocal error stays below 1/N for any magnitude below 2^MAG_W
  // as long as DIVISOR <= 16: mag * err < 2^(MAG_W+4) < 2^SHIFT.
  localparam int SHIFT   = MAG_W + $clog2(DIV_LIMIT) + 1;
  localparam int RECIP_W = SHIFT + 1;
  localparam longint unsigned RECIP =
    ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int QUOT_W  = SAMPLE_W + 1;

  logic                     neg;
  logic [SUM_W-1:0]         mag_full;
  logic [MAG_W-1:0]         mag;
  logic [RECIP_W-1:0]       recip;
  logic [PROD_W-1:0]        prod;
  logic [QUOT_W-1:0]        quot;
  logic [QUOT_W-1:0]        quot_signed;

  always_comb begin
    neg         = total[SUM_W-1];
    mag_full    = neg ? (~total + SUM_W'(1)) : total;
    mag         = mag_full[MAG_W-1:0];
    recip       = RECIP_W'(RECIP);
    prod        = PROD_W'(mag) * PROD_W'(recip);
    quot        = prod[SHIFT +: QUOT_W];
    quot_signed = neg ? (~quot + QUOT_W'(1)) : quot;
    average     = signed'(quot_signed[SAMPLE_W-1:0]);
  end

endmodule

FILE: rtl/twa_accum.sv
`timescale 1ns / 1ps

// Running totals, sample count and window phase.
// Closes a window into the handoff register on the last beat.
module twa_accum #(
  parameter int SAMPLES_PER_WINDOW = twa_pkg::DEF_SAMPLES_PER_WINDOW,
  parameter int SKIPPED_WINDOWS    = twa_pkg::DEF_SKIPPED_WINDOWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [twa_pkg::SAMPLE_W-1:0] temp_sample,
  input  logic signed [twa_pkg::SAMPLE_W-1:0] hum_sample,
  input  logic signed [twa_pkg::SAMPLE_W-1:0] dust_sample,
  output twa_pkg::twa_win_req_t               win_req,
  input  twa_pkg::twa_win_rsp_t               win_rsp,
  output twa_pkg::twa_window_t                win
);
  import twa_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_WINDOW > 1) ? $clog2(SAMPLES_PER_WINDOW) : 1;
  localparam int PH_W  = (SKIPPED_WINDOWS > 0) ? $clog2(SKIPPED_WINDOWS + 1) : 1;

  logic signed [SUM_W-1:0] temp_total, hum_total, dust_total;
  logic signed [SUM_W-1:0] temp_next, hum_next, dust_next;
  logic [CNT_W-1:0]        count;
  logic [PH_W-1:0]         phase;
  logic                    win_valid;
  logic                    count_last;
  logic                    phase_last;
  logic                    measuring;
  logic                    accept;

  always_comb begin
    count_last = (count == CNT_W'(SAMPLES_PER_WINDOW - 1));
    phase_last = (phase == PH_W'(SKIPPED_WINDOWS));
    measuring  = (phase == '0);
    // Only a closing beat needs the handoff register.
    in_stall   = win_valid && !win_rsp.take && count_last;
    accept     = in_valid && !in_stall;
    temp_next  = temp_total + SUM_W'(temp_sample);
    hum_next   = hum_total + SUM_W'(hum_sample);
    // Skipped windows report the held average, so their dust total is unused.
    dust_next  = dust_total + SUM_W'(dust_sample);
    win_req.valid = win_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_total <= '0;
      hum_total  <= '0;
      dust_total <= '0;
      count      <= '0;
      phase      <= '0;
      win_valid  <= 1'b0;
    end else begin
      // A new closing beat refills the register even as the old window leaves.
      if (accept && count_last) begin
        win_valid <= 1'b1;
      end else if (win_rsp.take) begin
        win_valid <= 1'b0;
      end
      if (accept) begin
        if (count_last) begin
          win.temp_total     <= temp_next;
          win.hum_total      <= hum_next;
          win.dust_total     <= dust_next;
          win.dust_measured  <= measuring;
          win.next_measures  <= phase_last;
          temp_total         <= '0;
          hum_total          <= '0;
          dust_total         <= '0;
          count              <= '0;
          phase              <= phase_last ? '0 : phase + PH_W'(1);
        end else begin
          temp_total <= temp_next;
          hum_total  <= hum_next;
          dust_total <= dust_next;
          count      <= count + CNT_W'(1);
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SAMPLES_PER_WINDOW - 1))
    else $error("sample count past window length");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_W'(SKIPPED_WINDOWS))
    else $error("window phase past skip count");

  a_close_loads: assert property (@(posedge clk) disable iff (rst)
    accept && count_last |=> win_valid && count == '0)
    else $error("closing beat did not load the window register");

endmodule

FILE: rtl/twa_out.sv
`timescale 1ns / 1ps

// Divides a closed window's totals, keeps the held dust average and
// drives the result register.
module twa_out #(
  parameter int SAMPLES_PER_WINDOW = twa_pkg::DEF_SAMPLES_PER_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  twa_pkg::twa_win_req_t                win_req,
  output twa_pkg::twa_win_rsp_t                win_rsp,
  input  twa_pkg::twa_window_t                 win,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [twa_pkg::SAMPLE_W-1:0]  temp_average,
  output logic signed [twa_pkg::SAMPLE_W-1:0]  hum_average,
  output logic signed [twa_pkg::SAMPLE_W-1:0]  dust_average,
  output logic                                 dust_was_measured,
  output logic                                 next_measures_dust
);
  import twa_pkg::*;

  logic signed [SAMPLE_W-1:0] temp_avg, hum_avg, dust_avg;
  logic signed [SAMPLE_W-1:0] held_dust;
  logic                       load;

  twa_div #(.DIVISOR(SAMPLES_PER_WINDOW)) u_div_temp (
    .total   (win.temp_total),
    .average (temp_avg)
  );

  twa_div #(.DIVISOR(SAMPLES_PER_WINDOW)) u_div_hum (
    .total   (win.hum_total),
    .average (hum_avg)
  );

  twa_div #(.DIVISOR(SAMPLES_PER_WINDOW)) u_div_dust (
    .total   (win.dust_total),
    .average (dust_avg)
  );

  always_comb begin
    load         = win_req.valid && (!out_valid || !out_stall);
    win_rsp.take = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_dust <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && win.dust_measured) begin
        held_dust <= dust_avg;
      end
    end
  end

  // N copies of the held value average back to the held value exactly.
  always_ff @(posedge clk) begin
    if (load) begin
      temp_average       <= temp_avg;
      hum_average        <= hum_avg;
      dust_average       <= win.dust_measured ? dust_avg : held_dust;
      dust_was_measured  <= win.dust_measured;
      next_measures_dust <= win.next_measures;
    end
  end

  a_held_tracks: assert property (@(posedge clk) disable iff (rst)
    load && win.dust_measured |=> held_dust == dust_average)
    else $error("held dust average out of step with measured result");

endmodule

FILE: rtl/three_channel_window_averager_top.sv
`timescale 1ns / 1ps

// Three-channel window averager. Each input beat carries one signed
// temperature, humidity and dust sample; the block sums each channel and,
// on every SAMPLES_PER_WINDOW-th beat, emits one result beat with the three
// window averages (truncated toward zero), then starts a fresh window. Dust
// is sampled live only in every (SKIPPED_WINDOWS+1)-th window, starting with
// the first after reset; other windows report the average of the last
// measured window. dust_was_measured flags a live window and
// next_measures_dust says whether the following window will be live.
// Rate: one input beat per clock, except while in_stall holds a closing
// beat. A result passes through the accumulator, which loads a window
// register, then the divide-by-constant stage (reciprocal multiply per
// channel), which loads the output register.
// in_stall rises only for a window-closing beat while both the window
// register and a stalled output register are full; ordinary beats are
// always taken.
module three_channel_window_averager_top #(
  parameter int SAMPLES_PER_WINDOW = twa_pkg::DEF_SAMPLES_PER_WINDOW,
  parameter int SKIPPED_WINDOWS    = twa_pkg::DEF_SKIPPED_WINDOWS
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [twa_pkg::SAMPLE_W-1:0] temp_sample,
  input  logic signed [twa_pkg::SAMPLE_W-1:0] hum_sample,
  input  logic signed [twa_pkg::SAMPLE_W-1:0] dust_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [twa_pkg::SAMPLE_W-1:0] temp_average,
  output logic signed [twa_pkg::SAMPLE_W-1:0] hum_average,
  output logic signed [twa_pkg::SAMPLE_W-1:0] dust_average,
  output logic                                dust_was_measured,
  output logic                                next_measures_dust
);
  import twa_pkg::*;

  twa_win_req_t win_req;
  twa_win_rsp_t win_rsp;
  twa_window_t  win;

  // Accumulate stage: totals, count, phase; loads the window register.
  twa_accum #(
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .SKIPPED_WINDOWS    (SKIPPED_WINDOWS)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .temp_sample (temp_sample),
    .hum_sample  (hum_sample),
    .dust_sample (dust_sample),
    .win_req     (win_req),
    .win_rsp     (win_rsp),
    .win         (win)
  );

  // Divide stage: constant divide, held dust, output register.
  twa_out #(
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW)
  ) u_out (
    .clk                (clk),
    .rst                (rst),
    .win_req            (win_req),
    .win_rsp            (win_rsp),
    .win                (win),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .temp_average       (temp_average),
    .hum_average        (hum_average),
    .dust_average       (dust_average),
    .dust_was_measured  (dust_was_measured),
    .next_measures_dust (next_measures_dust)
  );

  // Input backpressure only ever comes from a full, stalled result side.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && win_req.valid)
    else $error("input stalled with room downstream");

endmodule
